>>> src/rwct_pkg.sv
// ----------------------------------------------------------------------------
// rwct_pkg: shared types and codes for the rw conflict tracker
// Beat payload structs, function codes and sequencer states.
// ----------------------------------------------------------------------------
package rwct_pkg;

  typedef enum logic [2:0] {
    FUNC_REGISTER   = 3'd0,
    FUNC_UNREGISTER = 3'd1,
    FUNC_READ       = 3'd2,
    FUNC_WRITE      = 3'd3,
    FUNC_COMMIT     = 3'd4
  } func_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] xid;
    logic [31:0] tbl_id;
    logic [63:0] row_key;
  } in_beat_t;

  typedef struct packed {
    logic        status;
    logic [31:0] in_from_xid;
    logic [31:0] out_to_xid;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_CMP,
    ST_APPLY,
    ST_OUT
  } state_t;

endpackage

>>> src/rwct_ram.sv
// ----------------------------------------------------------------------------
// rwct_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module rwct_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                            wdata,
  output logic [WIDTH-1:0]                            rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> src/rw_conflict_tracker_unit.sv
// ----------------------------------------------------------------------------
// rw_conflict_tracker_unit: rw antidependency tracker top level
// Slot table, read-set RAM and the sequencer that walks it.
// ----------------------------------------------------------------------------
// One beat in, one beat out. The sequencer first finds the item's slot by a
// one-slot-a-cycle scan, then for record read walks that slot's read set and
// for check write walks the read set of every other active slot (id differing
// from the writer's) through the single read-set RAM port with a registered
// read: each entry passes ST_SCAN then ST_CMP, so the next entry is not
// addressed until the last one has been compared. The block takes no new beat
// until the result beat has been taken. No clearing pass: entries at or above
// a slot's read count are never compared.
module rw_conflict_tracker_unit #(
  parameter int MAX_TRANSACTIONS = 16,
  parameter int MAX_READS        = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rwct_pkg::in_beat_t  in_data,
  input  logic                out_ready,
  output logic                out_valid,
  output rwct_pkg::out_beat_t out_data
);
  import rwct_pkg::*;

  localparam int SW = (MAX_TRANSACTIONS > 1) ? $clog2(MAX_TRANSACTIONS) : 1;
  localparam int RW = (MAX_READS > 1) ? $clog2(MAX_READS) : 1;
  localparam int CW = $clog2(MAX_READS + 1);
  localparam int DEPTH = MAX_TRANSACTIONS * MAX_READS;
  localparam int AW = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;
  localparam int SWC = $clog2(MAX_TRANSACTIONS + 1);

  // slot table
  logic [MAX_TRANSACTIONS-1:0] act_r, rin_r, rout_r;
  logic [31:0] txid_r [MAX_TRANSACTIONS];
  logic [31:0] isrc_r [MAX_TRANSACTIONS];
  logic [31:0] otgt_r [MAX_TRANSACTIONS];
  logic [CW-1:0] cnt_r [MAX_TRANSACTIONS];

  state_t     st_r, st_nxt;
  in_beat_t   req_r;
  out_beat_t  res_r;
  logic [SWC-1:0] si_r;      // slot scan index (can reach depth)
  logic [CW-1:0]  ri_r;      // read-set scan index
  logic [SW-1:0]  own_r;     // lowest active slot with the id
  logic           own_ok_r;
  logic [SW-1:0]  free_r;
  logic           free_ok_r;
  logic           hit_r;

  // shared compare unit: one read entry against the request pair
  logic [95:0] rd;
  logic        eq;
  assign eq = (rd == {req_r.tbl_id, req_r.row_key});

  logic [SW-1:0] cur;        // slot whose read set is being walked
  assign cur = (req_r.func == FUNC_WRITE) ? si_r[SW-1:0] : own_r;

  logic [AW-1:0] addr;
  logic          we;
  always_comb begin
    addr = AW'(cur) * AW'(MAX_READS) + AW'(ri_r[RW-1:0]);
    if (st_r == ST_APPLY && req_r.func == FUNC_READ) begin
      addr = AW'(own_r) * AW'(MAX_READS) + AW'(cnt_r[own_r][RW-1:0]);
    end
  end
  assign we = (st_r == ST_APPLY) && (req_r.func == FUNC_READ) && own_ok_r
              && !hit_r && (cnt_r[own_r] < CW'(MAX_READS));

  rwct_ram #(.WIDTH(96), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr),
    .wdata({req_r.tbl_id, req_r.row_key}), .rdata(rd)
  );

  logic scan_last, set_end, walk_slot;
  assign scan_last = (si_r == SWC'(MAX_TRANSACTIONS - 1));
  assign set_end   = (ri_r >= cnt_r[cur]) || hit_r;
  assign walk_slot = act_r[si_r[SW-1:0]] && (txid_r[si_r[SW-1:0]] != req_r.xid);

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (in_valid) st_nxt = ST_LOOK;
      ST_LOOK: begin
        if (scan_last) begin
          if (req_r.xid == '0) st_nxt = ST_OUT;
          else if (req_r.func == FUNC_WRITE || req_r.func == FUNC_READ)
            st_nxt = ST_SCAN;
          else st_nxt = ST_APPLY;
        end
      end
      ST_SCAN: begin
        if (req_r.func == FUNC_READ) begin
          st_nxt = set_end ? ST_APPLY : ST_CMP;
        end else if (set_end || !walk_slot) begin
          st_nxt = scan_last ? ST_OUT : ST_SCAN;
        end else begin
          st_nxt = ST_CMP;
        end
      end
      ST_CMP:   st_nxt = ST_SCAN;
      ST_APPLY: st_nxt = ST_OUT;
      ST_OUT:   if (out_ready) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = (st_r == ST_IDLE);
    out_valid = (st_r == ST_OUT);
    out_data  = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      act_r  <= '0;
      rin_r  <= '0;
      rout_r <= '0;
      for (int i = 0; i < MAX_TRANSACTIONS; i++) begin
        txid_r[i] <= '0;
        isrc_r[i] <= '0;
        otgt_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      st_r <= st_nxt;
      case (st_r)
        ST_IDLE: begin
          req_r <= in_data;
          res_r <= '0;
          si_r <= '0;
          own_ok_r <= 1'b0;
          free_ok_r <= 1'b0;
          own_r <= '0;
          free_r <= '0;
        end
        ST_LOOK: begin
          if (act_r[si_r[SW-1:0]] && txid_r[si_r[SW-1:0]] == req_r.xid
              && !own_ok_r) begin
            own_ok_r <= 1'b1;
            own_r <= si_r[SW-1:0];
          end
          if (!act_r[si_r[SW-1:0]] && !free_ok_r) begin
            free_ok_r <= 1'b1;
            free_r <= si_r[SW-1:0];
          end
          si_r <= scan_last ? '0 : si_r + 1'b1;
          ri_r <= '0;
          // no owner on a read: nothing to walk or append
          hit_r <= scan_last && req_r.func == FUNC_READ && !own_ok_r
                   && !(act_r[si_r[SW-1:0]] && txid_r[si_r[SW-1:0]] == req_r.xid);
        end
        ST_SCAN: begin
          if (req_r.func == FUNC_WRITE && (set_end || !walk_slot)) begin
            if (hit_r && walk_slot) begin
              rin_r[si_r[SW-1:0]]  <= 1'b1;
              isrc_r[si_r[SW-1:0]] <= req_r.xid;
              if (own_ok_r) begin
                rout_r[own_r] <= 1'b1;
                otgt_r[own_r] <= txid_r[si_r[SW-1:0]];
              end
            end
            si_r  <= si_r + 1'b1;
            ri_r  <= '0;
            hit_r <= 1'b0;
          end
        end
        ST_CMP: begin
          // registered read of entry ri_r is now on rd
          if (eq) hit_r <= 1'b1;
          ri_r <= ri_r + 1'b1;
        end
        ST_APPLY: begin
          case (req_r.func)
            FUNC_REGISTER: if (free_ok_r) begin
              act_r[free_r]  <= 1'b1;
              txid_r[free_r] <= req_r.xid;
              rin_r[free_r]  <= 1'b0;
              rout_r[free_r] <= 1'b0;
              isrc_r[free_r] <= '0;
              otgt_r[free_r] <= '0;
              cnt_r[free_r]  <= '0;
            end
            FUNC_UNREGISTER: if (own_ok_r) act_r[own_r] <= 1'b0;
            FUNC_READ: if (we) cnt_r[own_r] <= cnt_r[own_r] + 1'b1;
            FUNC_COMMIT: if (own_ok_r && rin_r[own_r] && rout_r[own_r]) begin
              res_r.status      <= 1'b1;
              res_r.in_from_xid <= isrc_r[own_r];
              res_r.out_to_xid  <= otgt_r[own_r];
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // a result is only offered with the block closed to new beats
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && res_r.status |-> req_r.func == FUNC_COMMIT)
    else $error("failure on non-commit");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> own_ok_r) else $error("append without owner");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(res_r))
    else $error("result changed while stalled");
endmodule
